@@ rtl/quantum_scheduler_with_semaphores_defines.svh @@
// Assertion macros shared by the scheduler's checker.
`ifndef QUANTUM_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH
`define QUANTUM_SCHEDULER_WITH_SEMAPHORES_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define QS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qsched_pkg.sv @@
// Types and constants of the quantum scheduler with counting semaphores.
package qsched_pkg;

    // Fixed field widths.
    localparam int TASK_W     = 2;
    localparam int QUANT_W    = 8;
    localparam int SEM_W      = 8;
    localparam int TICK_W     = 32;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register map: priorities of the tasks start at this index.
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_BASE = 3'd0;

    // Reset values of the configuration registers.
    localparam logic [QUANT_W-1:0] PRIO_RESET [4] = '{8'd15, 8'd5, 8'd3, 8'd3};
    localparam logic signed [SEM_W-1:0] SEM_INIT_RESET [2] = '{8'sd1, 8'sd1};

    // Semaphore ceiling.
    localparam logic signed [SEM_W-1:0] SEM_MAX = 8'sd127;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SCHED = 2'd1,
        CMD_P     = 2'd2,
        CMD_V     = 2'd3
    } cmd_e;

    // One input word.
    typedef struct packed {
        cmd_e command;
        logic sem_index;
    } sched_in_t;

    // One result word.
    typedef struct packed {
        logic [TASK_W-1:0]       running_task;
        logic                    idle;
        logic [MASK_W-1:0]       blocked_mask;
        logic signed [SEM_W-1:0] sem_count;
        logic                    woke;
        logic [TASK_W-1:0]       woken_task;
        logic [TICK_W-1:0]       elapsed_ticks;
    } sched_out_t;

endpackage

@@ rtl/quantum_scheduler_with_semaphores.sv @@
// Top level of the quantum scheduler with counting semaphores.
// The block takes one command word at a time (tick, schedule, semaphore P or V) and
// returns one result word per command. After the accept cycle a command applies its
// update in the execute state, then a single shared compare unit walks the tasks one per
// cycle to find the unblocked task with the largest quantum (lowest index on a tie).
// When a reschedule finds no quantum left, a refill pass (one task per cycle) and a
// second walk follow. cmd_ready stays low until the result has been handed to the output
// register. A finished result waits in the output register, so the next command is
// accepted while it is pending. The semaphore counts load SEM_INIT_RESET at reset;
// writes to the initial-count register indices are accepted but have no effect.
module quantum_scheduler_with_semaphores
    import qsched_pkg::*;
#(
    parameter int NUM_TASKS  = 4,
    parameter int NUM_SEMS   = 2,
    parameter int WAIT_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  sched_in_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output sched_out_t            res
);

    localparam int TID_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PTR_W = $clog2(WAIT_DEPTH);
    localparam logic [TID_W-1:0] LAST_TID = TID_W'(NUM_TASKS - 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WAIT_DEPTH - 1);
    localparam logic signed [SEM_W-1:0] SEM_FLOOR = SEM_W'(-WAIT_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REFILL,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    cmd_e                    cmd_reg, cmd_next;
    logic                    sidx_reg, sidx_next;
    logic                    sem_ok_reg, sem_ok_next;
    logic                    sched_reg, sched_next;
    logic                    refilled_reg, refilled_next;
    logic [TID_W-1:0]        idx_reg, idx_next;
    logic [QUANT_W-1:0]      best_reg, best_next;
    logic [TID_W-1:0]        best_idx_reg, best_idx_next;
    logic                    idle_reg, idle_next;
    logic                    woke_reg, woke_next;
    logic [TID_W-1:0]        woken_reg, woken_next;
    logic [QUANT_W-1:0]      quant_reg [NUM_TASKS];
    logic [QUANT_W-1:0]      quant_next [NUM_TASKS];
    logic [QUANT_W-1:0]      prio_reg [NUM_TASKS];
    logic [QUANT_W-1:0]      prio_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]    blocked_reg, blocked_next;
    logic [TID_W-1:0]        cur_reg, cur_next;
    logic signed [SEM_W-1:0] sem_reg [NUM_SEMS];
    logic signed [SEM_W-1:0] sem_next [NUM_SEMS];
    logic [PTR_W-1:0]        head_reg [NUM_SEMS];
    logic [PTR_W-1:0]        head_next [NUM_SEMS];
    logic [PTR_W-1:0]        tail_reg [NUM_SEMS];
    logic [PTR_W-1:0]        tail_next [NUM_SEMS];
    logic [TICK_W-1:0]       ticks_reg, ticks_next;
    logic                    res_valid_reg, res_valid_next;
    sched_out_t              res_reg, res_next;

    // Wait queues, one row per semaphore, with a registered read port.
    logic [TID_W-1:0]        wait_mem [NUM_SEMS][WAIT_DEPTH];
    logic [TID_W-1:0]        rd_data_reg;
    logic                    mem_we;
    logic                    in_sem_ok;
    logic                    in_sel;

    // Shared compare and decrement unit on one quantum read port.
    logic [TID_W-1:0]        q_addr;
    logic [QUANT_W-1:0]      q_rd;
    logic                    take;
    logic [QUANT_W-1:0]      scan_best;
    logic [TID_W-1:0]        scan_idx;
    logic signed [SEM_W-1:0] sem_cur;
    logic signed [SEM_W-1:0] sem_upd;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Semaphore index of the incoming word, forced in range for addressing.
    assign in_sem_ok = (32'(cmd.sem_index) < NUM_SEMS);
    assign in_sel    = in_sem_ok ? cmd.sem_index : 1'b0;

    assign q_addr    = (state_reg == ST_EXEC) ? cur_reg : idx_reg;
    assign q_rd      = quant_reg[q_addr];
    assign take      = !blocked_reg[idx_reg] && (q_rd > best_reg);
    assign scan_best = take ? q_rd : best_reg;
    assign scan_idx  = take ? idx_reg : best_idx_reg;
    assign sem_cur   = sem_reg[sidx_reg];

    // Queue memory: the write pushes the running task, the read fetches the head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wait_mem[sidx_reg][tail_reg[sidx_reg]] <= cur_reg;
        end
        rd_data_reg <= wait_mem[in_sel][head_reg[in_sel]];
    end

    // Next-state logic of the sequencer and all of the scheduler state.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sidx_next      = sidx_reg;
        sem_ok_next    = sem_ok_reg;
        sched_next     = sched_reg;
        refilled_next  = refilled_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        idle_next      = idle_reg;
        woke_next      = woke_reg;
        woken_next     = woken_reg;
        quant_next     = quant_reg;
        prio_next      = prio_reg;
        blocked_next   = blocked_reg;
        cur_next       = cur_reg;
        sem_next       = sem_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        ticks_next     = ticks_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        sem_upd        = sem_cur;

        // Priority writes; writes to the initial-count indices have no effect.
        if (cfg_we)
        begin
            for (int t = 0; t < NUM_TASKS; t++)
            begin
                if (cfg_index == CFG_IDX_W'(32'(CFG_PRIO_BASE) + t))
                begin
                    prio_next[t] = cfg_data;
                end
            end
        end

        // The result register empties when its word is taken.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd.command;
                    sidx_next   = in_sel;
                    sem_ok_next = in_sem_ok;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                sched_next    = 1'b0;
                woke_next     = 1'b0;
                woken_next    = '0;
                idx_next      = '0;
                best_next     = '0;
                best_idx_next = '0;
                refilled_next = 1'b0;
                state_next    = ST_SCAN;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        ticks_next = ticks_reg + 1'b1;
                        if (q_rd != '0)
                        begin
                            quant_next[cur_reg] = q_rd - 1'b1;
                        end
                        sched_next = 1'b1;
                    end
                    CMD_SCHED:
                    begin
                        sched_next = 1'b1;
                    end
                    CMD_P:
                    begin
                        if (sem_ok_reg && (sem_cur > SEM_FLOOR))
                        begin
                            sem_upd = sem_cur - 8'sd1;
                            sem_next[sidx_reg] = sem_upd;
                            if (sem_upd < 8'sd0)
                            begin
                                mem_we = 1'b1;
                                tail_next[sidx_reg] = (tail_reg[sidx_reg] == LAST_PTR) ?
                                    '0 : tail_reg[sidx_reg] + 1'b1;
                                for (int t = 0; t < NUM_TASKS; t++)
                                begin
                                    if (cur_reg == TID_W'(t))
                                    begin
                                        blocked_next[t] = 1'b1;
                                    end
                                end
                                sched_next = 1'b1;
                            end
                        end
                    end
                    CMD_V:
                    begin
                        if (sem_ok_reg)
                        begin
                            if (sem_cur < SEM_MAX)
                            begin
                                sem_upd = sem_cur + 8'sd1;
                            end
                            sem_next[sidx_reg] = sem_upd;
                            if (sem_upd <= 8'sd0)
                            begin
                                woken_next = rd_data_reg;
                                woke_next  = 1'b1;
                                head_next[sidx_reg] = (head_reg[sidx_reg] == LAST_PTR) ?
                                    '0 : head_reg[sidx_reg] + 1'b1;
                                for (int t = 0; t < NUM_TASKS; t++)
                                begin
                                    if (rd_data_reg == TID_W'(t))
                                    begin
                                        blocked_next[t] = 1'b0;
                                    end
                                end
                                sched_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_SCAN;
                    end
                endcase
            end

            // One task per cycle through the shared compare.
            ST_SCAN:
            begin
                best_next     = scan_best;
                best_idx_next = scan_idx;
                if (idx_reg == LAST_TID)
                begin
                    if (sched_reg && (scan_best == '0) && !refilled_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_REFILL;
                    end
                    else
                    begin
                        if (sched_reg && (scan_best != '0))
                        begin
                            cur_next = scan_idx;
                        end
                        idle_next  = (scan_best == '0);
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Refill the unblocked tasks from their priorities, then pick again.
            ST_REFILL:
            begin
                if (!blocked_reg[idx_reg])
                begin
                    quant_next[idx_reg] = prio_reg[idx_reg];
                end
                if (idx_reg == LAST_TID)
                begin
                    idx_next      = '0;
                    best_next     = '0;
                    best_idx_next = '0;
                    refilled_next = 1'b1;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.running_task  = TASK_W'(cur_reg);
                    res_next.idle          = idle_reg;
                    res_next.blocked_mask  = MASK_W'(blocked_reg);
                    res_next.sem_count     = sem_ok_reg ? sem_cur : 8'sd0;
                    res_next.woke          = woke_reg;
                    res_next.woken_task    = TASK_W'(woken_reg);
                    res_next.elapsed_ticks = ticks_reg;
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_TICK;
            sidx_reg      <= 1'b0;
            sem_ok_reg    <= 1'b0;
            sched_reg     <= 1'b0;
            refilled_reg  <= 1'b0;
            idx_reg       <= '0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            idle_reg      <= 1'b0;
            woke_reg      <= 1'b0;
            woken_reg     <= '0;
            blocked_reg   <= '0;
            cur_reg       <= '0;
            ticks_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            for (int t = 0; t < NUM_TASKS; t++)
            begin
                quant_reg[t] <= '0;
                prio_reg[t]  <= PRIO_RESET[t];
            end
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                sem_reg[s]  <= SEM_INIT_RESET[s];
                head_reg[s] <= '0;
                tail_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            sidx_reg      <= sidx_next;
            sem_ok_reg    <= sem_ok_next;
            sched_reg     <= sched_next;
            refilled_reg  <= refilled_next;
            idx_reg       <= idx_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            idle_reg      <= idle_next;
            woke_reg      <= woke_next;
            woken_reg     <= woken_next;
            blocked_reg   <= blocked_next;
            cur_reg       <= cur_next;
            ticks_reg     <= ticks_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            quant_reg     <= quant_next;
            prio_reg      <= prio_next;
            sem_reg       <= sem_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

endmodule

@@ rtl/qsched_checker.sv @@
// Port-level checker of the quantum scheduler and its bind to the top level.
`include "quantum_scheduler_with_semaphores_defines.svh"

module qsched_checker
    import qsched_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input sched_out_t res
);

    // A stalled result word keeps its value.
    `QS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res), "result word changed while stalled")

    // A command occupies the block: no second word right after an accept.
    `QS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "command accepted while busy")

    // A released task only comes from a semaphore that still has waiters or just ran dry.
    `QS_ASSERT_NOW(a_woke_count, clk, rst_n, res_valid && res.woke, res.sem_count <= 8'sd0, "wake with positive count")

    // When some task can run, the running task is not blocked.
    `QS_ASSERT_NOW(a_run_unblocked, clk, rst_n, res_valid && !res.idle, !res.blocked_mask[res.running_task], "running task is blocked")

endmodule

bind quantum_scheduler_with_semaphores qsched_checker u_qsched_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

@@ dv/quantum_scheduler_with_semaphores_test.sv @@
// Self-checking testbench for the quantum scheduler: directed table, then random command traffic.
module quantum_scheduler_with_semaphores_test;
    import qsched_pkg::*;

    localparam int NTASK      = 4;
    localparam int QDEPTH     = 16;
    localparam int SETTLE     = 20;
    localparam int PHASE_HALF = 95;

    // Register index of the first initial-count register; the priorities start at CFG_PRIO_BASE.
    localparam logic [CFG_IDX_W-1:0] REG_SEM_INIT0 = 3'd4;

    // One row of the directed table, with an optional typed-in result word.
    typedef struct packed {
        cmd_e       command;
        logic       sem_index;
        logic       typed;
        sched_out_t want;
    } stim_row_t;

    typedef struct packed {
        logic       typed;
        sched_out_t want;
    } typed_tag_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    sched_in_t             cmd       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    sched_out_t            res;

    // Scheduler state as the predictor sees it.
    logic [QUANT_W-1:0] prio_reg [NTASK];
    logic [QUANT_W-1:0] quantum [NTASK];
    logic [MASK_W-1:0]  blocked;
    logic [TASK_W-1:0]  cur_task;
    int                 sem_val [2];
    logic [TASK_W-1:0]  wait_list [2][QDEPTH];
    logic [3:0]         wait_head [2];
    logic [3:0]         wait_tail [2];
    logic [TICK_W-1:0]  tick_count;

    // Words in flight and bookkeeping.
    sched_out_t expected_words [$];
    typed_tag_t typed_tags [$];
    stim_row_t  directed_rows [$];
    int         n_sent    = 0;
    int         n_checked = 0;
    int         n_fail    = 0;
    int         n_woke    = 0;
    int         n_idle    = 0;
    int         n_ceiling = 0;
    int         n_full    = 0;
    bit         calm      = 1'b0;
    bit         long_hold_req = 1'b0;

    sched_out_t predicted;
    sched_out_t oldest;
    typed_tag_t tag;

    quantum_scheduler_with_semaphores u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick the unblocked task with the largest quantum, lowest index on a tie.
    function automatic bit pick_ready();
        logic [QUANT_W-1:0] best;
        best = '0;
        for (int t = 0; t < NTASK; t++) begin
            if (!blocked[t] && quantum[t] > best) begin
                best = quantum[t];
                cur_task = t[TASK_W-1:0];
            end
        end
        return best != '0;
    endfunction

    // Reschedule, refilling every unblocked task when no quantum is left.
    function automatic void reschedule();
        if (pick_ready())
            return;
        for (int t = 0; t < NTASK; t++)
            if (!blocked[t])
                quantum[t] = prio_reg[t];
        void'(pick_ready());
    endfunction

    // Apply one command word to the predicted state and return the result word.
    function automatic sched_out_t predict_step(sched_in_t w);
        sched_out_t r;
        int         s;
        r = '0;
        s = int'(w.sem_index);
        case (w.command)
            CMD_TICK: begin
                tick_count = tick_count + 1;
                if (quantum[cur_task] != '0)
                    quantum[cur_task] = quantum[cur_task] - 1'b1;
                reschedule();
            end
            CMD_SCHED: reschedule();
            CMD_P: begin
                if (sem_val[s] > -QDEPTH) begin
                    sem_val[s] = sem_val[s] - 1;
                    if (sem_val[s] < 0) begin
                        wait_list[s][wait_tail[s]] = cur_task;
                        wait_tail[s] = wait_tail[s] + 1'b1;
                        blocked[cur_task] = 1'b1;
                        reschedule();
                    end
                end else begin
                    n_full++;
                end
            end
            default: begin
                if (sem_val[s] < SEM_MAX)
                    sem_val[s] = sem_val[s] + 1;
                else
                    n_ceiling++;
                if (sem_val[s] <= 0) begin
                    r.woken_task = wait_list[s][wait_head[s]];
                    wait_head[s] = wait_head[s] + 1'b1;
                    blocked[r.woken_task] = 1'b0;
                    r.woke = 1'b1;
                    n_woke++;
                    reschedule();
                end
            end
        endcase
        r.running_task = cur_task;
        r.idle = 1'b1;
        for (int t = 0; t < NTASK; t++)
            if (!blocked[t] && quantum[t] != '0)
                r.idle = 1'b0;
        if (r.idle)
            n_idle++;
        r.blocked_mask  = blocked;
        r.sem_count     = sem_val[s][SEM_W-1:0];
        r.elapsed_ticks = tick_count;
        return r;
    endfunction

    function automatic sched_out_t result_word(int task_id, int idl, int mask, int count,
                                               int wk, int wtask, int ticks);
        sched_out_t r;
        r.running_task  = task_id[TASK_W-1:0];
        r.idle          = idl[0];
        r.blocked_mask  = mask[MASK_W-1:0];
        r.sem_count     = count[SEM_W-1:0];
        r.woke          = wk[0];
        r.woken_task    = wtask[TASK_W-1:0];
        r.elapsed_ticks = ticks;
        return r;
    endfunction

    // Field-by-field comparison of one result word.
    task automatic compare_word(input sched_out_t want, input sched_out_t got);
        if (got.running_task !== want.running_task) begin
            $error("running_task: expected %0d, got %0d", want.running_task, got.running_task);
            n_fail++;
        end
        if (got.idle !== want.idle) begin
            $error("idle: expected %0d, got %0d", want.idle, got.idle);
            n_fail++;
        end
        if (got.blocked_mask !== want.blocked_mask) begin
            $error("blocked_mask: expected %b, got %b", want.blocked_mask, got.blocked_mask);
            n_fail++;
        end
        if (got.sem_count !== want.sem_count) begin
            $error("sem_count: expected %0d, got %0d", want.sem_count, got.sem_count);
            n_fail++;
        end
        if (got.woke !== want.woke) begin
            $error("woke: expected %0d, got %0d", want.woke, got.woke);
            n_fail++;
        end
        if (got.woken_task !== want.woken_task) begin
            $error("woken_task: expected %0d, got %0d", want.woken_task, got.woken_task);
            n_fail++;
        end
        if (got.elapsed_ticks !== want.elapsed_ticks) begin
            $error("elapsed_ticks: expected %0d, got %0d", want.elapsed_ticks,
                   got.elapsed_ticks);
            n_fail++;
        end
    endtask

    // Accepted commands feed the predictor; accepted results are checked in order.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_valid && cmd_ready) begin
                predicted = predict_step(cmd);
                tag = (typed_tags.size() != 0) ? typed_tags.pop_front() : '0;
                expected_words.push_back(tag.typed ? tag.want : predicted);
            end
            if (res_valid && res_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    n_fail++;
                end else begin
                    oldest = expected_words.pop_front();
                    compare_word(oldest, res);
                    n_checked++;
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold on request, none while calm.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                res_ready <= 1'b0;
                stall_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = 300;
                res_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // Offer one command word, after an optional gap, and wait for it to be taken.
    task automatic offer(input cmd_e c, input logic s, input logic typed, input sched_out_t want);
        sched_in_t w;
        int        gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 8);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        w.command   = c;
        w.sem_index = s;
        typed_tags.push_back('{typed, want});
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic send(input cmd_e c, input logic s);
        offer(c, s, 1'b0, '0);
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (n_checked < n_sent) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0][7:0] prios, input logic [1:0][3:0] inits);
        for (int t = 0; t < NTASK; t++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(CFG_PRIO_BASE + t);
            cfg_data  <= prios[t];
            prio_reg[t] = prios[t];
            @(posedge clk);
        end
        for (int s = 0; s < 2; s++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(REG_SEM_INIT0 + s);
            cfg_data  <= {4'b0, inits[s]};
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly well-formed semaphore and tick sequences, some noise.
    task automatic run_traffic(input int n);
        int   stop;
        int   kind;
        int   len;
        logic s;
        stop = n_sent + n;
        while (n_sent < stop) begin
            kind = $urandom_range(0, 99);
            s    = 1'($urandom_range(0, 1));
            if (kind < 15) begin
                len = $urandom_range(1, 6);
                repeat (len) send(cmd_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end else if (kind < 40) begin
                len = $urandom_range(4, 30);
                repeat (len)
                    send(($urandom_range(0, 5) == 0) ? CMD_SCHED : CMD_TICK,
                         1'($urandom_range(0, 1)));
            end else if (kind < 60) begin
                len = $urandom_range(1, 20);
                repeat (len) send(CMD_P, s);
            end else if (kind < 80) begin
                len = $urandom_range(1, 20);
                repeat (len) send(CMD_V, s);
            end else begin
                // Lock, run for a while, unlock.
                len = $urandom_range(1, 8);
                repeat (len) begin
                    send(CMD_P, s);
                    repeat ($urandom_range(0, 3)) send(CMD_TICK, s);
                    send(CMD_V, s);
                end
            end
        end
    endtask

    initial begin
        logic [3:0][7:0] prios;
        logic [1:0][3:0] inits;

        for (int t = 0; t < NTASK; t++) begin
            prio_reg[t] = PRIO_RESET[t];
            quantum[t]  = '0;
        end
        for (int s = 0; s < 2; s++) begin
            sem_val[s]      = int'(SEM_INIT_RESET[s]);
            wait_head[s]    = '0;
            wait_tail[s]    = '0;
            for (int i = 0; i < QDEPTH; i++)
                wait_list[s][i] = '0;
        end
        blocked    = '0;
        cur_task   = '0;
        tick_count = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The first rows follow straight from the reset state.
        directed_rows.push_back('{CMD_SCHED, 1'b0, 1'b1, result_word(0, 0, 0, 1, 0, 0, 0)});
        directed_rows.push_back('{CMD_TICK, 1'b1, 1'b1, result_word(0, 0, 0, 1, 0, 0, 1)});
        directed_rows.push_back('{CMD_P, 1'b0, 1'b1, result_word(0, 0, 0, 0, 0, 0, 1)});
        directed_rows.push_back('{CMD_P, 1'b0, 1'b1, result_word(1, 0, 1, -1, 0, 0, 1)});
        directed_rows.push_back('{CMD_V, 1'b0, 1'b1, result_word(0, 0, 0, 0, 1, 0, 1)});
        directed_rows.push_back('{CMD_V, 1'b1, 1'b1, result_word(0, 0, 0, 2, 0, 0, 1)});
        // Block every task on semaphore 1 until nothing is eligible.
        repeat (6) directed_rows.push_back('{CMD_P, 1'b1, 1'b0, '0});
        // A P while the kept current task is already blocked queues it again.
        directed_rows.push_back('{CMD_P, 1'b1, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, 1'b0, 1'b0, '0});
        directed_rows.push_back('{CMD_SCHED, 1'b1, 1'b0, '0});
        // Release the waiters in queue order.
        repeat (5) directed_rows.push_back('{CMD_V, 1'b1, 1'b0, '0});
        directed_rows.push_back('{CMD_V, 1'b0, 1'b0, '0});
        directed_rows.push_back('{CMD_TICK, 1'b1, 1'b0, '0});
        foreach (directed_rows[i])
            offer(directed_rows[i].command, directed_rows[i].sem_index,
                  directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin prios = {8'd255, 8'd255, 8'd255, 8'd255}; inits = {4'd15, 4'd15}; end
                1: begin prios = {8'd0, 8'd0, 8'd0, 8'd0};         inits = {4'd0, 4'd0};   end
                2: begin prios = {8'd1, 8'd255, 8'd0, 8'd1};       inits = {4'd7, 4'd8};   end
                4: begin prios = {8'd3, 8'd3, 8'd5, 8'd15};        inits = {4'd1, 4'd1};   end
                default: begin
                    for (int t = 0; t < NTASK; t++)
                        prios[t] = (t == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 12));
                    inits = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
                end
            endcase
            program_regs(prios, inits);
            calm = (ph == 5);
            // The result side holds off long enough for the input to back up.
            if (ph == 1)
                long_hold_req = 1'b1;
            // Drive each semaphore to its ceiling and then down to a full wait queue.
            if (ph == 3) begin
                for (int s = 0; s < 2; s++) begin
                    repeat (145) send(CMD_V, 1'(s));
                    repeat (145) send(CMD_P, 1'(s));
                end
            end
            run_traffic(PHASE_HALF);
            if (ph == 2)
                drain();
            run_traffic(PHASE_HALF);
            drain();
        end

        $display("Checked %0d of %0d command words over six register settings: %0d wakeups, %0d idle.",
                 n_checked, n_sent, n_woke, n_idle);
        $display("Semaphore ceiling hit %0d times, full wait queue hit %0d times.",
                 n_ceiling, n_full);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial begin
        #5000000;
        $display("Timeout with %0d of %0d words checked.", n_checked, n_sent);
        $display("TEST FAILED");
        $finish;
    end

endmodule
